>>> hdl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker package
// Shared widths, codes, state encoding and helper functions for the walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int unsigned DEF_NUM_TABLE_FRAMES = 16;

  localparam int unsigned IDX_W      = 9;
  localparam int unsigned ENTRIES    = 512;
  localparam int unsigned PAGE_W     = 12;
  localparam int unsigned FRAME_W    = 44;
  localparam int unsigned PA_W       = 56;
  localparam int unsigned VA_W       = 64;
  localparam int unsigned PTE_W      = 64;
  localparam int unsigned SLOT_IN_W  = 4;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CANON_LSB  = 38;
  localparam int unsigned PPN_LSB    = 10;
  localparam int unsigned RSVD_LSB   = 54;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned REG_SEL_BIT = 3;

  // Command codes carried by the request channel.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_WALK  = 1'b1;

  // Register select codes, taken from one address bit.
  localparam logic REG_MAX_FRAME  = 1'b0;
  localparam logic REG_TABLE_BASE = 1'b1;

  // Level codes of the walk.
  localparam logic [LEVEL_W-1:0] LVL_4K  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_2M  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_1G  = 2'd2;

  localparam logic [PAGE_W-1:0] PAGE_MASK = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_BAD_ADDR   = 2'd2,
    ST_BAD_PARAM  = 2'd3
  } ptw_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_CHECK,
    S_FINISH
  } ptw_state_e;

  typedef struct packed {
    ptw_status_e          status;
    logic [PA_W-1:0]      physical_address;
    logic [LEVEL_W-1:0]   leaf_level;
    logic                 global_seen;
    logic [PTE_W-1:0]     leaf_entry;
    logic [FRAME_W-1:0]   leaf_table_frame;
    logic [IDX_W-1:0]     leaf_entry_index;
  } ptw_res_t;

  // Frame-number span covered by a leaf at the given level, minus one.
  function automatic logic [FRAME_W-1:0] leaf_span(input logic [LEVEL_W-1:0] level);
    logic [FRAME_W-1:0] span;
    span = '0;
    case (level)
      LVL_2M:  span = FRAME_W'({IDX_W{1'b1}});
      LVL_1G:  span = FRAME_W'({2*IDX_W{1'b1}});
      default: span = '0;
    endcase
    return span;
  endfunction

  // Virtual page number field used as the table index at the given level.
  function automatic logic [IDX_W-1:0] vpn_index(input logic [VA_W-1:0] va,
                                                 input logic [LEVEL_W-1:0] level);
    logic [IDX_W-1:0] idx;
    idx = '0;
    case (level)
      LVL_4K:  idx = va[PAGE_W +: IDX_W];
      LVL_2M:  idx = va[PAGE_W + IDX_W +: IDX_W];
      LVL_1G:  idx = va[PAGE_W + 2*IDX_W +: IDX_W];
      default: idx = '0;
    endcase
    return idx;
  endfunction

endpackage

>>> hdl/ptw_if.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker channels
// Valid/ready request and response interfaces of the walker.
// ----------------------------------------------------------------------------
interface ptw_req_if;
  import ptw_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [SLOT_IN_W-1:0] write_slot;
  logic [IDX_W-1:0]     write_index;
  logic [PTE_W-1:0]     pte_value;
  logic [FRAME_W-1:0]   root_frame;
  logic [VA_W-1:0]      virtual_address;

  modport source (
    output valid, cmd, write_slot, write_index, pte_value, root_frame, virtual_address,
    input  ready
  );

  modport sink (
    input  valid, cmd, write_slot, write_index, pte_value, root_frame, virtual_address,
    output ready
  );
endinterface

interface ptw_rsp_if;
  import ptw_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [PA_W-1:0]      physical_address;
  logic [LEVEL_W-1:0]   leaf_level;
  logic                 global_seen;
  logic [PTE_W-1:0]     leaf_entry;
  logic [FRAME_W-1:0]   leaf_table_frame;
  logic [IDX_W-1:0]     leaf_entry_index;

  modport source (
    output valid, status, physical_address, leaf_level, global_seen, leaf_entry,
           leaf_table_frame, leaf_entry_index,
    input  ready
  );

  modport sink (
    input  valid, status, physical_address, leaf_level, global_seen, leaf_entry,
           leaf_table_frame, leaf_entry_index,
    output ready
  );
endinterface

>>> hdl/sv39_page_table_walker.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker: a write or a rejected walk goes from the idle state straight
// to the finish state; a walk passes an address and a check state per level read.
// The finish state loads the response register, stalling while an earlier response
// waits, then returns to idle. After reset a clearing pass zeroes the store first.
// Each level uses an address state and a check state on the single table store port;
// a table frame outside the store ends the walk after its address state.
// ----------------------------------------------------------------------------
module sv39_page_table_walker #(
  parameter int unsigned NUM_TABLE_FRAMES = ptw_pkg::DEF_NUM_TABLE_FRAMES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ptw_req_if.sink                           req_i,
  ptw_rsp_if.source                         rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ptw_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ptw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ptw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import ptw_pkg::*;

  // The table store holds NUM_TABLE_FRAMES frames of 512 entries each. A frame
  // slot and an entry index concatenate into the store address.
  localparam int unsigned SLOT_W = (NUM_TABLE_FRAMES > 1) ? $clog2(NUM_TABLE_FRAMES) : 1;
  localparam int unsigned ADDR_W = SLOT_W + IDX_W;
  localparam int unsigned DEPTH  = NUM_TABLE_FRAMES * ENTRIES;
  localparam logic [ADDR_W-1:0]  LAST_ADDR    = ADDR_W'(DEPTH - 1);
  localparam logic [FRAME_W-1:0] NUM_FRAMES_F = FRAME_W'(NUM_TABLE_FRAMES);

  // Sequencer and control state.
  ptw_state_e          state_q, state_d;
  logic [ADDR_W-1:0]   clr_cnt_q;
  logic [FRAME_W-1:0]  max_frame_q;
  logic [FRAME_W-1:0]  base_frame_q;
  logic                out_valid_q;

  // Walk datapath registers.
  logic [FRAME_W-1:0]  table_q;
  logic [VA_W-1:0]     va_q;
  logic [LEVEL_W-1:0]  level_q;
  logic                global_q;
  ptw_res_t            res_q, res_d;
  logic                res_load;
  ptw_res_t            out_q;

  // Table store.
  logic [PTE_W-1:0]    mem [DEPTH];
  logic [PTE_W-1:0]    rdata_q;
  logic [ADDR_W-1:0]   mem_addr;
  logic                mem_we;
  logic [PTE_W-1:0]    mem_wdata;

  logic                req_fire;
  logic                out_free;
  logic                cfg_write;
  logic                slot_ok;
  logic                root_bad;
  logic                va_canon;

  assign req_fire  = req_i.valid && req_i.ready;
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign slot_ok   = 32'(req_i.write_slot) < NUM_TABLE_FRAMES;
  assign root_bad  = req_i.root_frame > max_frame_q;
  assign va_canon  = (req_i.virtual_address[VA_W-1:CANON_LSB] == '0) ||
                     (req_i.virtual_address[VA_W-1:CANON_LSB] == '1);

  // --------------------------------------------------------------------------
  // Shared frame lookup unit. It maps the current table frame to a store slot
  // and is reused for every level of the walk.
  // --------------------------------------------------------------------------
  logic [FRAME_W-1:0]  tbl_diff;
  logic                tbl_hit;
  logic [SLOT_W-1:0]   tbl_slot;
  logic [IDX_W-1:0]    cur_idx;

  assign tbl_diff = table_q - base_frame_q;
  assign tbl_hit  = (table_q >= base_frame_q) && (tbl_diff < NUM_FRAMES_F);
  assign tbl_slot = tbl_diff[SLOT_W-1:0];
  assign cur_idx  = vpn_index(va_q, level_q);

  // --------------------------------------------------------------------------
  // Shared entry check unit. It decodes the entry read at the current level
  // and applies the validity, leaf and alignment checks of the walk.
  // --------------------------------------------------------------------------
  logic                pte_v, pte_r, pte_w, pte_x, pte_u, pte_g, pte_a, pte_d;
  logic [FRAME_W-1:0]  pte_frame;
  logic [FRAME_W-1:0]  span;
  logic [FRAME_W:0]    span_end;
  logic                pte_bad;
  logic                pte_leaf;
  logic                leaf_misfit;
  logic                branch_bad;
  logic                global_now;
  logic [PA_W-1:0]     leaf_pa;

  assign pte_v     = rdata_q[0];
  assign pte_r     = rdata_q[1];
  assign pte_w     = rdata_q[2];
  assign pte_x     = rdata_q[3];
  assign pte_u     = rdata_q[4];
  assign pte_g     = rdata_q[5];
  assign pte_a     = rdata_q[6];
  assign pte_d     = rdata_q[7];
  assign pte_frame = rdata_q[PPN_LSB +: FRAME_W];
  assign span      = leaf_span(level_q);
  assign span_end  = {1'b0, pte_frame} + {1'b0, span};

  assign pte_bad     = (|rdata_q[PTE_W-1:RSVD_LSB]) || (pte_w && !pte_r) ||
                       (pte_frame > max_frame_q);
  assign pte_leaf    = pte_r || pte_x;
  // The frame is already known not to exceed the limit; the end of the span
  // carries an extra bit, so it is compared against the limit without overflow.
  assign leaf_misfit = (|(pte_frame & span)) || (span_end > {1'b0, max_frame_q});
  assign branch_bad  = (level_q == LVL_4K) || pte_u || pte_a || pte_d;
  assign global_now  = global_q || pte_g;
  assign leaf_pa     = {pte_frame, {PAGE_W{1'b0}}} | (va_q[PA_W-1:0] & {span, PAGE_MASK});

  // --------------------------------------------------------------------------
  // Next-state logic of the sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          if (req_i.cmd == CMD_WRITE || root_bad || !va_canon) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        state_d = tbl_hit ? S_CHECK : S_FINISH;
      end
      S_CHECK: begin
        if (!pte_v || pte_bad || pte_leaf || branch_bad) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_ADDR;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result selection. The result is captured whenever the sequencer leaves
  // for the finish state; every failure leaves the data fields at zero.
  // --------------------------------------------------------------------------
  always_comb begin
    res_d    = '0;
    res_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        res_load = req_fire;
        if (req_i.cmd == CMD_WRITE) begin
          res_d.status = slot_ok ? ST_OK : ST_BAD_PARAM;
        end else if (root_bad) begin
          res_d.status = ST_BAD_PARAM;
        end else if (!va_canon) begin
          res_d.status = ST_BAD_ADDR;
        end
      end
      S_ADDR: begin
        res_load     = !tbl_hit;
        res_d.status = ST_BAD_ADDR;
      end
      S_CHECK: begin
        res_load = 1'b1;
        if (!pte_v) begin
          res_d.status = ST_NOT_MAPPED;
        end else if (pte_bad) begin
          res_d.status = ST_BAD_ADDR;
        end else if (pte_leaf) begin
          if (leaf_misfit) begin
            res_d.status = ST_BAD_ADDR;
          end else begin
            res_d.status           = ST_OK;
            res_d.physical_address = leaf_pa;
            res_d.leaf_level       = level_q;
            res_d.global_seen      = global_now;
            res_d.leaf_entry       = rdata_q;
            res_d.leaf_table_frame = table_q;
            res_d.leaf_entry_index = cur_idx;
          end
        end else if (branch_bad) begin
          res_d.status = ST_BAD_ADDR;
        end else begin
          res_load = 1'b0;
        end
      end
      S_CLEAR, S_FINISH: begin
        res_load = 1'b0;
      end
      default: res_load = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output logic: channel ready, store port control and register readback.
  // New requests are taken in the idle state even while an earlier response
  // still waits in the output register.
  // --------------------------------------------------------------------------
  always_comb begin
    req_i.ready = (state_q == S_IDLE);
    mem_we      = 1'b0;
    mem_wdata   = req_i.pte_value;
    mem_addr    = {tbl_slot, cur_idx};
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        mem_addr  = clr_cnt_q;
      end
      S_IDLE: begin
        mem_we   = req_fire && (req_i.cmd == CMD_WRITE) && slot_ok;
        mem_addr = {SLOT_W'(req_i.write_slot), req_i.write_index};
      end
      S_ADDR, S_CHECK, S_FINISH: begin
        mem_we = 1'b0;
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign pready = 1'b1;
  assign prdata = (paddr[REG_SEL_BIT] == REG_TABLE_BASE) ? APB_DATA_W'(base_frame_q)
                                                         : APB_DATA_W'(max_frame_q);

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = out_q.status;
  assign rsp_o.physical_address = out_q.physical_address;
  assign rsp_o.leaf_level       = out_q.leaf_level;
  assign rsp_o.global_seen      = out_q.global_seen;
  assign rsp_o.leaf_entry       = out_q.leaf_entry;
  assign rsp_o.leaf_table_frame = out_q.leaf_table_frame;
  assign rsp_o.leaf_entry_index = out_q.leaf_entry_index;

  // --------------------------------------------------------------------------
  // Control registers with reset.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_cnt_q    <= '0;
      max_frame_q  <= '1;
      base_frame_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      if (cfg_write) begin
        if (paddr[REG_SEL_BIT] == REG_MAX_FRAME) begin
          max_frame_q <= pwdata[FRAME_W-1:0];
        end else begin
          base_frame_q <= pwdata[FRAME_W-1:0];
        end
      end
      if (state_q == S_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Walk datapath and result registers; these need no reset.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_fire) begin
      table_q  <= req_i.root_frame;
      va_q     <= req_i.virtual_address;
      level_q  <= LVL_1G;
      global_q <= 1'b0;
    end else if (state_q == S_CHECK && !res_load) begin
      // Descend one level through a valid pointer entry.
      table_q  <= pte_frame;
      level_q  <= level_q - LEVEL_W'(1);
      global_q <= global_now;
    end
    if (res_load) begin
      res_q <= res_d;
    end
    if (state_q == S_FINISH && out_free) begin
      out_q <= res_q;
    end
  end

  // Single-port table store with a registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_OK) |->
      (rsp_o.physical_address == '0 && rsp_o.leaf_entry == '0 &&
       rsp_o.leaf_table_frame == '0 && rsp_o.global_seen == 1'b0))
    else $error("failed response carries nonzero data");

  a_store_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_IDLE))
    else $error("table store written during a walk");

  a_check_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (level_q == LVL_4K || level_q == LVL_2M || level_q == LVL_1G))
    else $error("walk level out of range");

  a_success_leaf_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_OK && rsp_o.leaf_entry != '0) |->
      (rsp_o.leaf_entry[0] && (rsp_o.leaf_entry[1] || rsp_o.leaf_entry[3])))
    else $error("successful walk ended on a non-leaf entry");
`endif

endmodule
